>>> sv/joint_goto_velocity_controller_unit_macros.svh
// Assertion helpers used by the top block to check its own control logic.
`ifndef JOINT_GOTO_VELOCITY_CONTROLLER_UNIT_MACROS_SVH
`define JOINT_GOTO_VELOCITY_CONTROLLER_UNIT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define JGVC_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define JGVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/jgvc_pkg.sv
package jgvc_pkg;

	localparam int NUM_JOINTS_DEF = 7;
	localparam int RAMP_DEPTH_DEF = 256;
	localparam int NUM_POS        = 7;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int NORM_W = 35;

	localparam logic [16:0] PHASE_FULL = 17'h1_0000;
	localparam longint      Q30_ONE    = 64'sd1073741824;

	localparam longint SIN_COEF [6] = '{
		64'sd1686629713, -64'sd693598668, 64'sd85569305,
		-64'sd5026992, 64'sd172272, -64'sd3864
	};

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] REG_GAIN      = 2'd0;
	localparam logic [1:0] REG_SPEED_LIM = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_PHASE_STEP = 2'd3;

	// stage strobes shared by the lanes, the ramp lookup and the merge
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} lane_ctrl_t;

	// raised-cosine ramp entry, Q.16, from a Q.30 phase u in [0, 1)
	function automatic logic [16:0] ramp_entry(input longint u);
		longint      u2;
		longint      acc;
		logic [63:0] sq;
		int          c;
		u2  = (u * u) / Q30_ONE;
		acc = SIN_COEF[5];
		for (c = 4; c >= 0; c--) begin
			acc = SIN_COEF[c] + (u2 * acc) / Q30_ONE;
		end
		acc = (u * acc) / Q30_ONE;
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > Q30_ONE) begin
			acc = Q30_ONE;
		end
		sq = 64'(acc) * 64'(acc);
		return 17'((sq + 64'h0000_0800_0000_0000) >> 44);
	endfunction

endpackage

>>> sv/jgvc_ramp.sv
module jgvc_ramp #(
	parameter int RAMP_TABLE_DEPTH = jgvc_pkg::RAMP_DEPTH_DEF
) (
	input  logic                 clk,
	input  jgvc_pkg::lane_ctrl_t ctrl,
	input  logic [16:0]          phase,
	output logic [16:0]          ramp_s1,
	output logic                 ramping_s1
);
	import jgvc_pkg::*;

	localparam int IDX_W = (RAMP_TABLE_DEPTH > 1) ? $clog2(RAMP_TABLE_DEPTH) : 1;
	localparam int PRD_W = 16 + IDX_W;

	logic [16:0]      tbl_w [RAMP_TABLE_DEPTH];
	logic [PRD_W-1:0] idx_prod_w;
	logic [IDX_W-1:0] idx_w;

	for (genvar k = 0; k < RAMP_TABLE_DEPTH; k++) begin : g_tbl
		localparam longint      U   = (longint'(k) << 30) / RAMP_TABLE_DEPTH;
		localparam logic [16:0] ENT = ramp_entry(U);
		assign tbl_w[k] = ENT;
	end

	// only used while phase is below full scale, so the index stays below depth
	assign idx_prod_w = PRD_W'(phase[15:0]) * PRD_W'(RAMP_TABLE_DEPTH);
	assign idx_w      = idx_prod_w[PRD_W-1:16];

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			ramp_s1    <= tbl_w[idx_w];
			ramping_s1 <= (phase < PHASE_FULL);
		end
	end

endmodule

>>> sv/jgvc_lane.sv
module jgvc_lane (
	input  logic                 clk,
	input  jgvc_pkg::lane_ctrl_t ctrl,
	input  logic                 target_we,
	input  logic signed [15:0]   goal_pos,
	input  logic signed [15:0]   pos,
	input  logic [15:0]          gain,
	input  logic [14:0]          speed_lim,
	input  logic [16:0]          ramp,
	input  logic                 ramping,
	output logic [31:0]          sq_s2,
	output logic signed [15:0]   vel_s4
);
	import jgvc_pkg::*;

	logic signed [15:0] target_q;
	logic signed [15:0] pos_s1;
	logic [31:0]        prod_s2;
	logic               neg_s2;
	logic [20:0]        scaled_s3;
	logic               neg_s3;

	logic signed [16:0] err_w;
	logic [16:0]        err_neg_w;
	logic [15:0]        mag_w;
	logic [47:0]        ramped_w;
	logic [47:0]        ramped_rnd_w;
	logic [32:0]        plain_rnd_w;
	logic [20:0]        scaled_w;
	logic [14:0]        clamp_w;

	assign err_w     = {target_q[15], target_q} - {pos_s1[15], pos_s1};
	assign err_neg_w = 17'(-err_w);
	assign mag_w     = err_w[16] ? err_neg_w[15:0] : err_w[15:0];

	assign ramped_w     = {16'b0, prod_s2} * {31'b0, ramp};
	assign ramped_rnd_w = ramped_w + 48'h0000_0800_0000;
	assign plain_rnd_w  = {1'b0, prod_s2} + 33'h0_0000_0800;
	assign scaled_w     = ramping ? 21'(ramped_rnd_w >> 28) : 21'(plain_rnd_w >> 12);

	assign clamp_w = (scaled_s3 > {6'b0, speed_lim}) ? speed_lim : scaled_s3[14:0];

	always_ff @(posedge clk) begin
		if (target_we) begin
			target_q <= goal_pos;
		end
		if (ctrl.en_s1) begin
			pos_s1 <= pos;
		end
		if (ctrl.en_s2) begin
			prod_s2 <= {16'b0, mag_w} * {16'b0, gain};
			sq_s2   <= {16'b0, mag_w} * {16'b0, mag_w};
			neg_s2  <= err_w[16];
		end
		if (ctrl.en_s3) begin
			scaled_s3 <= scaled_w;
			neg_s3    <= neg_s2;
		end
		if (ctrl.en_s4) begin
			vel_s4 <= neg_s3 ? -$signed({1'b0, clamp_w}) : $signed({1'b0, clamp_w});
		end
	end

endmodule

>>> sv/jgvc_merge.sv
module jgvc_merge #(
	parameter int LANES = jgvc_pkg::NUM_JOINTS_DEF
) (
	input  logic                 clk,
	input  jgvc_pkg::lane_ctrl_t ctrl,
	input  logic [31:0]          sq [LANES],
	input  logic [32:0]          threshold,
	output logic                 reached_s4
);
	import jgvc_pkg::*;

	logic [NORM_W-1:0] sum_w;
	logic [NORM_W-1:0] norm_s3;

	always_comb begin
		sum_w = '0;
		for (int k = 0; k < LANES; k++) begin
			sum_w = sum_w + NORM_W'(sq[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			norm_s3 <= sum_w;
		end
		if (ctrl.en_s4) begin
			reached_s4 <= (norm_s3 < NORM_W'(threshold));
		end
	end

endmodule

>>> sv/joint_goto_velocity_controller_unit.sv
// Proportional joint velocity controller with raised-cosine soft start. A load word
// (func 0) stores one joint target, restarts the ramp and arms the controller; it is
// taken while idle and gives nothing back. A tick word (func 1) runs all joints
// through parallel lanes of four register stages (position capture with ramp table
// lookup, gain and squared-error multiply, ramp multiply with rounding, clamp), the
// first of them loaded at the accepting edge, so the velocity word is valid from the
// edge that loads the clamp stage; the error norm is summed from the lanes and
// compared in the same stages. One tick is in flight at a time, and each word waits
// for out_ready; the all-zero stop word marked last follows the final velocity word.
// Ticks after a stop word, or before any load, are taken with no output.
// Registers sit on an APB port at byte addresses 0, 8, 16 and 24
// (gain, speed limit, stop_threshold_sq, ramp_phase_step), 64-bit data.
`include "joint_goto_velocity_controller_unit_macros.svh"

module joint_goto_velocity_controller_unit #(
	parameter int NUM_JOINTS       = jgvc_pkg::NUM_JOINTS_DEF,
	parameter int RAMP_TABLE_DEPTH = jgvc_pkg::RAMP_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jgvc_pkg::ADDR_W-1:0] paddr,
	input  logic [jgvc_pkg::DATA_W-1:0] pwdata,
	output logic [jgvc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [2:0]                  joint_index,
	input  logic signed [15:0]          goal_pos,
	input  logic signed [15:0]          pos_0,
	input  logic signed [15:0]          pos_1,
	input  logic signed [15:0]          pos_2,
	input  logic signed [15:0]          pos_3,
	input  logic signed [15:0]          pos_4,
	input  logic signed [15:0]          pos_5,
	input  logic signed [15:0]          pos_6,
	input  logic                        preempt,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          vel_0,
	output logic signed [15:0]          vel_1,
	output logic signed [15:0]          vel_2,
	output logic signed [15:0]          vel_3,
	output logic signed [15:0]          vel_4,
	output logic signed [15:0]          vel_5,
	output logic signed [15:0]          vel_6,
	output logic                        reached,
	output logic                        aborted,
	output logic                        last
);
	import jgvc_pkg::*;

	localparam int LANES = (NUM_JOINTS < NUM_POS) ? NUM_JOINTS : NUM_POS;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_VEL  = 4'b0100,
		ST_STOP = 4'b1000
	} state_t;

	state_t      state_q;
	logic [2:0]  stg_q;
	logic        finished_q;
	logic [16:0] phase_q;
	logic        preempt_q;

	logic [15:0] gain_q;
	logic [14:0] speed_lim_q;
	logic [32:0] threshold_q;
	logic [16:0] phase_step_q;

	logic       cfg_we_w;
	logic [1:0] cfg_idx_w;

	logic       acc_w;
	logic       acc_tick_w;
	logic       acc_load_w;
	logic       stop_w;
	logic [17:0] phase_next_w;
	lane_ctrl_t ctrl_w;

	logic [16:0]        ramp_s1;
	logic               ramping_s1;
	logic               reached_s4;
	logic signed [15:0] pos_w [NUM_POS];
	logic signed [15:0] vel_w [NUM_POS];
	logic [31:0]        sq_w  [LANES];

	// configuration port
	assign pready    = 1'b1;
	assign cfg_idx_w = paddr[4:3];
	assign cfg_we_w  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx_w)
			REG_GAIN:       prdata = DATA_W'(gain_q);
			REG_SPEED_LIM:  prdata = DATA_W'(speed_lim_q);
			REG_THRESHOLD:  prdata = DATA_W'(threshold_q);
			REG_PHASE_STEP: prdata = DATA_W'(phase_step_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= 16'd4096;
			speed_lim_q  <= 15'd2048;
			threshold_q  <= 33'd167772;
			phase_step_q <= 17'd131;
		end else if (cfg_we_w) begin
			unique case (cfg_idx_w)
				REG_GAIN:       gain_q       <= pwdata[15:0];
				REG_SPEED_LIM:  speed_lim_q  <= pwdata[14:0];
				REG_THRESHOLD:  threshold_q  <= pwdata[32:0];
				REG_PHASE_STEP: phase_step_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// control
	assign in_ready   = (state_q == ST_IDLE);
	assign acc_w      = in_valid && in_ready;
	assign acc_tick_w = acc_w && (func == FUNC_TICK) && !finished_q;
	assign acc_load_w = acc_w && (func == FUNC_LOAD);
	assign stop_w     = reached_s4 || preempt_q;

	assign ctrl_w.en_s1 = acc_tick_w;
	assign ctrl_w.en_s2 = stg_q[0];
	assign ctrl_w.en_s3 = stg_q[1];
	assign ctrl_w.en_s4 = stg_q[2];

	assign phase_next_w = {1'b0, phase_q} + {1'b0, phase_step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stg_q      <= '0;
			finished_q <= 1'b1;
			phase_q    <= '0;
		end else begin
			stg_q <= {stg_q[1:0], acc_tick_w};
			unique case (state_q)
				ST_IDLE: begin
					if (acc_tick_w) begin
						state_q <= ST_CALC;
					end
					if (acc_load_w) begin
						phase_q    <= '0;
						finished_q <= 1'b0;
					end
				end
				ST_CALC: begin
					if (stg_q[2]) begin
						state_q <= ST_VEL;
					end
				end
				ST_VEL: begin
					if (out_ready) begin
						if (stop_w) begin
							state_q    <= ST_STOP;
							finished_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
							phase_q <= (phase_next_w > {1'b0, PHASE_FULL}) ?
								PHASE_FULL : phase_next_w[16:0];
						end
					end
				end
				ST_STOP: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_tick_w) begin
			preempt_q <= preempt;
		end
	end

	// datapath
	assign pos_w[0] = pos_0;
	assign pos_w[1] = pos_1;
	assign pos_w[2] = pos_2;
	assign pos_w[3] = pos_3;
	assign pos_w[4] = pos_4;
	assign pos_w[5] = pos_5;
	assign pos_w[6] = pos_6;

	jgvc_ramp #(
		.RAMP_TABLE_DEPTH(RAMP_TABLE_DEPTH)
	) u_ramp (
		.clk       (clk),
		.ctrl      (ctrl_w),
		.phase     (phase_q),
		.ramp_s1   (ramp_s1),
		.ramping_s1(ramping_s1)
	);

	for (genvar k = 0; k < NUM_POS; k++) begin : g_lane
		if (k < LANES) begin : g_on
			jgvc_lane u_lane (
				.clk       (clk),
				.ctrl      (ctrl_w),
				.target_we (acc_load_w && (joint_index == 3'(k))),
				.goal_pos  (goal_pos),
				.pos       (pos_w[k]),
				.gain      (gain_q),
				.speed_lim (speed_lim_q),
				.ramp      (ramp_s1),
				.ramping   (ramping_s1),
				.sq_s2     (sq_w[k]),
				.vel_s4    (vel_w[k])
			);
		end else begin : g_off
			assign vel_w[k] = '0;
		end
	end

	jgvc_merge #(
		.LANES(LANES)
	) u_merge (
		.clk       (clk),
		.ctrl      (ctrl_w),
		.sq        (sq_w),
		.threshold (threshold_q),
		.reached_s4(reached_s4)
	);

	// output word: velocities first, then the zero stop word
	assign out_valid = (state_q == ST_VEL) || (state_q == ST_STOP);
	assign last      = (state_q == ST_STOP);
	assign reached   = last && reached_s4;
	assign aborted   = last && !reached_s4 && preempt_q;
	assign vel_0     = last ? '0 : vel_w[0];
	assign vel_1     = last ? '0 : vel_w[1];
	assign vel_2     = last ? '0 : vel_w[2];
	assign vel_3     = last ? '0 : vel_w[3];
	assign vel_4     = last ? '0 : vel_w[4];
	assign vel_5     = last ? '0 : vel_w[5];
	assign vel_6     = last ? '0 : vel_w[6];

	`JGVC_ASSERT_HOLDS(a_no_input_while_word, !(out_valid && in_ready), "input taken while a word waits")
	`JGVC_ASSERT_HOLDS(a_one_stage_live, $onehot0(stg_q), "more than one tick in the lane pipeline")
	`JGVC_ASSERT_NEXT(a_stop_follows, (state_q == ST_VEL) && out_ready && stop_w, (state_q == ST_STOP) && finished_q, "stop word missing after final velocity word")
	`JGVC_ASSERT_HOLDS(a_phase_saturates, phase_q <= PHASE_FULL, "ramp phase beyond full scale")

endmodule
